/* hw/rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/bb3_pkg.sv */
// Types and constants of the 3x3 box blur.
package bb3_pkg;

	// register index taken from paddr[2]
	localparam logic RegWidth  = 1'b0;
	localparam logic RegHeight = 1'b1;

	// reciprocals: floor(a/3) = (a*5462)>>14, floor(a/9) = (a*7282)>>16, exact for a < 4096
	localparam logic [12:0] RecipThree = 13'd5462;
	localparam int          ShiftThree = 14;
	localparam logic [12:0] RecipNine  = 13'd7282;
	localparam int          ShiftNine  = 16;

	// neighbor counts that occur
	localparam logic [3:0] CntOne   = 4'd1;
	localparam logic [3:0] CntTwo   = 4'd2;
	localparam logic [3:0] CntThree = 4'd3;
	localparam logic [3:0] CntFour  = 4'd4;
	localparam logic [3:0] CntSix   = 4'd6;
	localparam logic [3:0] CntNine  = 4'd9;

	// one neighborhood: px[row*3+col], mask of in-frame neighbors, frame end flag
	typedef struct packed {
		logic [8:0][23:0] px;
		logic [8:0]       msk;
		logic             fend;
	} win_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		F_IDLE,
		F_UPD
	} front_state_t;

endpackage

/* hw/rtl/box_blur_3x3_edge_aware.sv */
// A result passes the line buffer read, queue, sum and output registers.
// After a pixel the input is not ready until the single-port line buffer, read on the
// transfer cycle, is written back in the next one; ignored flushes do not hold it.
// Reset (arst_n low, asynchronous): counters and queue cleared, frame 640x480;
// line buffer contents stay undefined and are masked until written in the frame.
module box_blur_3x3_edge_aware #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red_in, green_in, blue_in
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // red_out, green_out, blue_out
	output logic        m_tlast   // frame_end
);
	import bb3_pkg::*;

	logic [10:0] width_q, eff_w;
	logic [15:0] height_q, eff_h;
	logic        cfg_wr, push, pop;
	win_t        push_data, pop_data;
	q_stat_t     q_stat;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 16'd480;
		end else if (cfg_wr) begin
			if (paddr[2] == RegWidth) width_q  <= pwdata[10:0];
			else                      height_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == RegHeight) ? {16'd0, height_q} : {21'd0, width_q};

	// effective frame size
	always_comb begin
		priority if (width_q == 11'd0)              eff_w = 11'd1;
		else if (32'(width_q) > MAX_WIDTH)          eff_w = 11'(MAX_WIDTH);
		else                                        eff_w = width_q;
		eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	bb3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	bb3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* hw/rtl/bb3_front.sv */
// Front end: input handshake, position counters, line buffers and window.
module bb3_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr,
	input  logic [10:0]      eff_w,
	input  logic [15:0]      eff_h,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,  // red, green, blue
	input  logic             s_tuser,  // action
	input  bb3_pkg::q_stat_t q_stat,
	output logic             push,
	output bb3_pkg::win_t    push_data
);
	import bb3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	front_state_t   state_q, state_d;
	logic [16:0]    in_row_q;
	logic [CW-1:0]  in_col_q;
	logic [15:0]    out_row_q;
	logic [CW-1:0]  out_col_q;
	logic [23:0]    pix_q;
	logic [47:0]    rd_q;
	logic [2:0][23:0] col1_q, col2_q, newcol;
	logic [47:0]    lb_mem [MAX_WIDTH];

	logic acc, in_live, go, upd, emit;
	logic in_col_wrap, out_col_wrap, out_row_done;
	logic [2:0] rowv, colv;

	// transfer classification
	assign acc     = s_tvalid & s_tready;
	assign in_live = in_row_q < {1'b0, eff_h};
	assign go      = acc & ~(in_live & s_tuser);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (go) state_d = F_UPD;
			F_UPD:  state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = (state_q == F_IDLE) && !q_stat.full;
		upd      = (state_q == F_UPD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= F_IDLE;
		else         state_q <= state_d;
	end

	// line buffers: read on a transfer that is not ignored, write back on update
	always_ff @(posedge clk) begin
		if (go) begin
			rd_q  <= lb_mem[in_col_q];
			pix_q <= in_live ? s_tdata : 24'd0;
		end
		if (upd) lb_mem[in_col_q] <= {rd_q[23:0], pix_q};
	end

	// new window column: older row, newer row, current pixel
	assign newcol[0] = rd_q[47:24];
	assign newcol[1] = rd_q[23:0];
	assign newcol[2] = pix_q;

	always_ff @(posedge clk) begin
		if (upd) begin
			col1_q <= col2_q;
			col2_q <= newcol;
		end
	end

	// result due and its neighbor mask
	assign emit = (in_row_q >= 17'd2) || ((in_row_q == 17'd1) && (in_col_q != '0));
	assign in_col_wrap  = (32'(in_col_q) + 32'd1) >= 32'(eff_w);
	assign out_col_wrap = (32'(out_col_q) + 32'd1) >= 32'(eff_w);
	assign out_row_done = (32'(out_row_q) + 32'd1) >= 32'(eff_h);
	assign rowv = {(32'(out_row_q) + 32'd1) < 32'(eff_h), 1'b1, out_row_q != 16'd0};
	assign colv = {!out_col_wrap, 1'b1, out_col_q != '0};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			push_data.px[i*3+0] = col1_q[i];
			push_data.px[i*3+1] = col2_q[i];
			push_data.px[i*3+2] = newcol[i];
			for (int j = 0; j < 3; j++) push_data.msk[i*3+j] = rowv[i] & colv[j];
		end
		push_data.fend = out_row_done && out_col_wrap &&
			((32'(out_row_q) + 32'd1) == 32'(eff_h));
	end

	assign push = upd & emit;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_wr || (upd && emit && out_col_wrap && out_row_done)) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (upd) begin
			if (in_col_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + 17'd1;
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
			if (emit) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 16'd1;
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

endmodule

/* hw/rtl/bb3_queue.sv */
// Two-entry queue between front end and back end.
module bb3_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bb3_pkg::win_t    push_data,
	input  logic             pop,
	output bb3_pkg::win_t    pop_data,
	output bb3_pkg::q_stat_t q_stat
);
	import bb3_pkg::*;

	win_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);
	assign do_push  = push & ~q_stat.full;
	assign do_pop   = pop & ~q_stat.empty;
	assign pop_data = ent_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

/* hw/rtl/bb3_back.sv */
// Back end: masked channel sums, rounded division, output register.
module bb3_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bb3_pkg::win_t    pop_data,
	input  bb3_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,  // red, green, blue
	output logic             m_tlast   // frame_end
);
	import bb3_pkg::*;

	// rounded mean: (2*sum + cnt) / (2*cnt)
	function automatic logic [7:0] mean8(input logic [11:0] sum, input logic [3:0] cnt);
		logic [12:0] n;
		logic [11:0] a3;
		logic [24:0] p3, p9;
		logic [7:0]  r;
		n  = {sum, 1'b0} + 13'(cnt);
		a3 = (cnt == CntSix) ? {1'b0, n[12:2]} : n[12:1];
		p3 = 25'(a3) * 25'(RecipThree);
		p9 = 25'(n[12:1]) * 25'(RecipNine);
		unique case (cnt)
			CntOne:   r = n[8:1];
			CntTwo:   r = n[9:2];
			CntFour:  r = n[10:3];
			CntThree: r = p3[ShiftThree +: 8];
			CntSix:   r = p3[ShiftThree +: 8];
			CntNine:  r = p9[ShiftNine +: 8];
			default:  r = n[8:1];
		endcase
		return r;
	endfunction

	logic             adv;
	logic             v_s1;
	logic [2:0][11:0] sum_s1;
	logic [3:0]       cnt_s1;
	logic             fend_s1;
	logic [2:0][11:0] sum_d;

	assign adv = ~(m_tvalid & ~m_tready);
	assign pop = adv & ~q_stat.empty;

	// masked sums over the nine neighbors
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_d[c] = '0;
			for (int k = 0; k < 9; k++)
				if (pop_data.msk[k]) sum_d[c] = sum_d[c] + 12'(pop_data.px[k][c*8 +: 8]);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1     <= pop;
			m_tvalid <= v_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			sum_s1  <= sum_d;
			cnt_s1  <= 4'($countones(pop_data.msk));
			fend_s1 <= pop_data.fend;
		end
		if (adv && v_s1) begin
			for (int c = 0; c < 3; c++) m_tdata[c*8 +: 8] <= mean8(sum_s1[c], cnt_s1);
			m_tlast <= fend_s1;
		end
	end

endmodule

/* hw/rtl/bb3_checker.sv */
// Port-level checks of the box blur, bound to the top level.
`include "assert_macros.svh"

module bb3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// a pixel transfer is followed by the line buffer write-back, with the input not ready
	`ASSERT_NEXT(a_pix_busy, clk, arst_n, s_tvalid && s_tready && !s_tuser, !s_tready)

	// width written is read back in the next cycle
	`ASSERT_SAME(a_width_rb, clk, arst_n, $past(psel && penable && pwrite && pready && paddr[2] == 1'b0) && psel && !pwrite && paddr[2] == 1'b0, prdata[10:0] == $past(pwdata[10:0]))

endmodule

bind box_blur_3x3_edge_aware bb3_checker u_bb3_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the streaming 3x3 edge-aware box blur.
module testbench;
	import bb3_pkg::*;

	localparam logic ActPixel = 1'b0;
	localparam logic ActFlush = 1'b1;
	localparam int   MaxCols  = 1024;
	localparam int   StallLimit = 5000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       fend;
	} blur_px_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [23:0] s_tdata;  // red_in, green_in, blue_in
	logic        s_tuser;  // action
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;  // red_out, green_out, blue_out
	logic        m_tlast;  // frame_end

	box_blur_3x3_edge_aware DUT (.*);

	// shadow copy of the blur state
	logic [10:0] cfg_width;
	logic [15:0] cfg_height;
	logic [23:0] row_older [MaxCols];
	logic [23:0] row_newer [MaxCols];
	logic [23:0] win [9];
	longint      in_r, in_c, out_r, out_c;

	blur_px_t pending_means[$];
	bit       steady;
	int       sent, frames_done;
	int       errors = 0;
	int       means_seen = 0;
	int       stall_cnt = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint width_used();
		if (cfg_width == 0) return 1;
		if (cfg_width > MaxCols) return MaxCols;
		return cfg_width;
	endfunction

	function automatic longint height_used();
		return (cfg_height == 0) ? 1 : cfg_height;
	endfunction

	function automatic void restart_frame();
		in_r = 0; in_c = 0; out_r = 0; out_c = 0;
	endfunction

	// mean over in-frame neighbors; k is the window offset of the center column
	function automatic blur_px_t window_mean(longint k, longint w, longint h);
		int sr, sg, sb, cnt;
		longint row, col;
		blur_px_t o;
		sr = 0; sg = 0; sb = 0; cnt = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				row = out_r - 1 + i;
				col = out_c - k + j;
				if (row < 0 || row >= h || col < 0 || col >= w) continue;
				if (col < out_c - 1 || col > out_c + 1) continue;
				sr += win[i*3+j][23:16];
				sg += win[i*3+j][15:8];
				sb += win[i*3+j][7:0];
				cnt++;
			end
		if (cnt == 0) cnt = 1;
		o.red   = 8'((2*sr + cnt) / (2*cnt));
		o.green = 8'((2*sg + cnt) / (2*cnt));
		o.blue  = 8'((2*sb + cnt) / (2*cnt));
		o.fend  = (out_r * w + out_c + 1 == w * h);
		return o;
	endfunction

	// advance the shadow state by one accepted item; returns 1 with a result
	function automatic bit blur_predict(logic act, logic [23:0] data, output blur_px_t o);
		longint w, h, q, x;
		logic [23:0] px;
		bit emit, got;
		w = width_used(); h = height_used(); got = 0;
		if (in_c >= w) restart_frame();
		q = in_r * w + in_c;
		if (in_r < h) begin
			if (act == ActFlush) return 0;
			px = {data[7:0], data[15:8], data[23:16]};
		end else begin
			px = '0;
		end
		x = in_c;
		emit = (q >= w + 1);
		if (emit && x == 0) begin
			o = window_mean(2, w, h); got = 1;
		end
		for (int i = 0; i < 3; i++) begin
			win[i*3]   = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = row_older[x];
		win[5] = row_newer[x];
		win[8] = px;
		row_older[x] = row_newer[x];
		row_newer[x] = px;
		if (emit && x >= 1) begin
			o = window_mean(1, w, h); got = 1;
		end
		in_c++;
		if (in_c >= w) begin
			in_c = 0; in_r++;
		end
		if (emit) begin
			out_c++;
			if (out_c >= w) begin
				out_c = 0; out_r++;
			end
			if (out_r >= h) restart_frame();
		end
		return got;
	endfunction

	// send one item; the valid stays high after the transfer until the next call
	task automatic send_item(logic act, logic [23:0] data);
		blur_px_t o;
		if (!steady && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		sent++;
		if (blur_predict(act, data, o)) pending_means.push_back(o);
	endtask

	// hold input low, let every expected result arrive, then cover latency
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_means.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		wait_drained();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == RegWidth) cfg_width = val[10:0];
		else cfg_height = val[15:0];
		restart_frame();
	endtask

	task automatic set_frame(logic [31:0] w, logic [31:0] h);
		write_reg(RegWidth, w);
		write_reg(RegHeight, h);
	endtask

	// one full frame with random content, then drain flushes
	task automatic run_frame(bit noisy);
		longint n;
		n = width_used() * height_used();
		for (longint i = 0; i < n; i++) begin
			if (noisy && $urandom_range(9) == 0) send_item(ActFlush, 24'($urandom()));
			send_item(ActPixel, 24'($urandom()));
		end
		// late pixels act as flushes too
		for (longint i = 0; i <= width_used(); i++)
			send_item($urandom_range(1) ? ActFlush : ActPixel, 24'($urandom()));
		if (noisy) repeat ($urandom_range(2)) send_item(ActFlush, 24'($urandom()));
		frames_done++;
	endtask

	task automatic test_directed();
		set_frame(3, 2);
		send_item(ActFlush, 24'h000000);   // early flush is ignored
		send_item(ActPixel, 24'hFFFFFF);
		send_item(ActPixel, 24'h000000);
		send_item(ActPixel, 24'hFF00FF);
		send_item(ActFlush, 24'hFFFFFF);
		send_item(ActPixel, 24'h00FF00);
		send_item(ActPixel, 24'hFFFFFF);
		send_item(ActPixel, 24'h808080);
		repeat (4) send_item(ActFlush, 24'h0);
		send_item(ActFlush, 24'h0);        // nothing left to drain
		// 1x1 frame, then width and height zero read as one
		set_frame(1, 1);
		send_item(ActPixel, 24'hFFFFFF);
		send_item(ActFlush, 24'h0);
		send_item(ActPixel, 24'h010203);
		send_item(ActPixel, 24'h0);        // first pixel of the next frame
		set_frame(0, 0);
		send_item(ActPixel, 24'h7F7F7F);
		send_item(ActFlush, 24'h0);
		frames_done += 4;
	endtask

	// oversize width clamps (no result within the first line), and the tallest height
	task automatic test_extreme_sizes();
		steady = 1;
		set_frame(2047, 2);
		repeat (60) send_item(ActPixel, 24'($urandom()));
		steady = 0;
		set_frame(1, 65535);
		repeat (40) send_item(ActPixel, 24'($urandom()));
		wait_drained();
	endtask

	task automatic test_random_frames();
		int start;
		start = sent;
		set_frame($urandom_range(1, 6), $urandom_range(1, 5));
		while (sent - start < 480) begin
			steady = ($urandom_range(7) == 0);
			if ($urandom_range(3) != 0) begin
				if ($urandom_range(9) == 0) set_frame($urandom_range(16, 40), $urandom_range(1, 3));
				else set_frame($urandom_range(1, 6), $urandom_range(1, 5));
			end
			run_frame(1);
			if ($urandom_range(4) == 0) wait_drained();
		end
		steady = 0;
		// a long stretch with no idling on either side
		steady = 1;
		set_frame(5, 4);
		run_frame(0);
		run_frame(0);
		steady = 0;
	endtask

	// output ready control and result checking
	always @(posedge clk or negedge arst_n) begin
		blur_px_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 34);
			if (m_tvalid && m_tready) begin
				means_seen++;
				if (pending_means.size() == 0) begin
					$display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
					errors++;
				end else begin
					e = pending_means.pop_front();
					if (m_tdata[7:0] !== e.red || m_tdata[15:8] !== e.green
							|| m_tdata[23:16] !== e.blue || m_tlast !== e.fend) begin
						$display("%0t: expected r%h g%h b%h last %b, got r%h g%h b%h last %b",
							$time, e.red, e.green, e.blue, e.fend,
							m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast);
						errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= StallLimit) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_tvalid = 0; s_tdata = '0; s_tuser = ActPixel;
		steady = 0; sent = 0; frames_done = 0;
		cfg_width = 11'd640; cfg_height = 16'd480;
		foreach (win[i]) win[i] = '0;
		foreach (row_older[i]) begin
			row_older[i] = '0; row_newer[i] = '0;
		end
		restart_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_extreme_sizes();
		test_random_frames();
		wait_drained();
		$display("Covered %0d items in %0d frames, %0d blurred pixels checked,",
			sent, frames_done, means_seen);
		$display("sizes from 1x1 to 40 wide, a clamped oversize width, 65535 tall, and drains.");
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
